>>> design/rth_pkg.sv
`timescale 1ns / 1ps

package rth_pkg;

	// Field widths.
	localparam int ChanW   = 8;
	localparam int HueW    = 9;
	localparam int SatW    = 8;

	// Hue offset quotient never exceeds 60; saturation quotient never exceeds 255.
	localparam int HueQuoW = 6;
	localparam int SatQuoW = 8;

	// 120 * mag + spread fits 15 bits; 510 * spread + max fits 17 bits.
	localparam int HueNumW = 15;
	localparam int SatNumW = 17;
	localparam int DenW    = ChanW + 1;

	// One quotient bit per divider stage, sized for the wider quotient.
	localparam int DivStages = SatQuoW;

	// Sum of base angle and signed offset before the wrap, 60..420.
	localparam int HueSumW = 10;

	localparam int HueFull    = 360;
	localparam int HueGreen   = 120;
	localparam int HueBlue    = 240;
	localparam int HueSector  = 120;
	localparam int SatScale2  = 510;

	// Which channel is the largest; picks the base angle.
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} rth_sector_t;

	// Everything one pixel carries through the divider stages.
	typedef struct packed {
		logic [HueNumW-1:0] hue_rem;
		logic [DenW-1:0]    hue_den;
		logic [HueQuoW-1:0] hue_quo;
		logic [SatNumW-1:0] sat_rem;
		logic [DenW-1:0]    sat_den;
		logic [SatQuoW-1:0] sat_quo;
		logic               grey;
		logic               black;
		rth_sector_t        sector;
		logic               neg;
		logic [ChanW-1:0]   value;
	} rth_div_t;

endpackage

>>> design/rth_divider.sv
`timescale 1ns / 1ps

module rth_divider (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rth_pkg::rth_div_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output rth_pkg::rth_div_t out_data
);
	import rth_pkg::*;

	// Restoring division, one quotient bit per stage, most significant first.
	// Both the hue and the saturation divisions advance in lockstep.
	logic [DivStages:0]     stage_ready;
	logic [DivStages:0]     stage_valid;
	rth_div_t               stage_in [DivStages+1];
	rth_div_t               stage_next [DivStages];
	logic [DivStages-1:0]   div_valid_s;
	rth_div_t               div_data_s [DivStages];

	assign stage_valid[0]         = in_valid;
	assign stage_in[0]            = in_data;
	assign stage_ready[DivStages] = out_ready;
	assign in_ready               = stage_ready[0];
	assign out_valid              = stage_valid[DivStages];
	assign out_data               = stage_in[DivStages];

	for (genvar k = 0; k < DivStages; k++) begin : g_stage
		localparam int Bit = DivStages - 1 - k;

		logic [HueNumW+DivStages-1:0] hue_trial;
		logic [SatNumW+DivStages-1:0] sat_trial;

		assign hue_trial = (HueNumW+DivStages)'(stage_in[k].hue_den) << Bit;
		assign sat_trial = (SatNumW+DivStages)'(stage_in[k].sat_den) << Bit;

		always_comb begin
			stage_next[k] = stage_in[k];
			if ((HueNumW+DivStages)'(stage_in[k].hue_rem) >= hue_trial) begin
				stage_next[k].hue_rem = stage_in[k].hue_rem - hue_trial[HueNumW-1:0];
				stage_next[k].hue_quo = stage_in[k].hue_quo | (HueQuoW'(1) << Bit);
			end
			if ((SatNumW+DivStages)'(stage_in[k].sat_rem) >= sat_trial) begin
				stage_next[k].sat_rem = stage_in[k].sat_rem - sat_trial[SatNumW-1:0];
				stage_next[k].sat_quo = stage_in[k].sat_quo | (SatQuoW'(1) << Bit);
			end
		end

		assign stage_ready[k]    = !div_valid_s[k] || stage_ready[k+1];
		assign stage_valid[k+1]  = div_valid_s[k];
		assign stage_in[k+1]     = div_data_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_s[k] <= 1'b0;
			end else if (stage_ready[k]) begin
				div_valid_s[k] <= stage_valid[k];
			end
		end

		always_ff @(posedge clk) begin
			if (stage_ready[k] && stage_valid[k]) begin
				div_data_s[k] <= stage_next[k];
			end
		end
	end

endmodule

>>> design/rgb_to_hsv_pixel_unit.sv
`timescale 1ns / 1ps

// RGB to HSV pixel converter.
//
// Input channel (pix_valid / pix_stall) carries one pixel per beat as 8-bit
// red_in, green_in and blue_in. Output channel (hsv_valid / hsv_stall) carries
// one result per beat: hue_deg in whole degrees 0..359, saturation_out 0..255
// and value_out, the largest channel. Every pixel gives exactly one result.
//
// The datapath is an 11-stage pipeline: channel compare, numerator products,
// eight stages of restoring division (one quotient bit each) and the hue wrap.
// A new pixel can be taken every cycle while pix_stall is low, so the
// throughput is one pixel per clock.
//
// When the receiver stalls, the stalled beat holds and the stages behind it
// keep filling; empty stages close up, so pix_stall only rises once every
// stage holds a pixel. No beat is dropped or repeated across a stall.
//
// Reset clears every valid bit; no result is presented until a pixel enters.
// There is no configuration and no state carried from one pixel to the next.
module rgb_to_hsv_pixel_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_stall,
	input  logic [rth_pkg::ChanW-1:0]   red_in,
	input  logic [rth_pkg::ChanW-1:0]   green_in,
	input  logic [rth_pkg::ChanW-1:0]   blue_in,
	output logic                        hsv_valid,
	input  logic                        hsv_stall,
	output logic [rth_pkg::HueW-1:0]    hue_deg,
	output logic [rth_pkg::SatW-1:0]    saturation_out,
	output logic [rth_pkg::ChanW-1:0]   value_out
);
	import rth_pkg::*;

	// Stage 1: find the largest and smallest channel and the hue sector.
	logic [ChanW-1:0]  max_c;
	logic [ChanW-1:0]  min_c;
	logic [ChanW-1:0]  hi_c;
	logic [ChanW-1:0]  lo_c;
	rth_sector_t       sector_c;

	always_comb begin
		// Ties go to red first, then green.
		if (red_in >= green_in && red_in >= blue_in) begin
			sector_c = SECT_RED;
			max_c    = red_in;
			hi_c     = green_in;
			lo_c     = blue_in;
		end else if (green_in >= blue_in) begin
			sector_c = SECT_GREEN;
			max_c    = green_in;
			hi_c     = blue_in;
			lo_c     = red_in;
		end else begin
			sector_c = SECT_BLUE;
			max_c    = blue_in;
			hi_c     = red_in;
			lo_c     = green_in;
		end
		min_c = red_in;
		if (green_in < min_c) begin
			min_c = green_in;
		end
		if (blue_in < min_c) begin
			min_c = blue_in;
		end
	end

	logic              valid_s1;
	logic              ready_s1;
	logic [ChanW-1:0]  value_s1;
	logic [ChanW-1:0]  spread_s1;
	logic [ChanW-1:0]  mag_s1;
	logic              neg_s1;
	rth_sector_t       sector_s1;

	logic              valid_s2;
	logic              ready_s2;
	rth_div_t          data_s2;

	assign ready_s1  = !valid_s1 || ready_s2;
	assign pix_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && pix_valid) begin
			value_s1  <= max_c;
			spread_s1 <= max_c - min_c;
			mag_s1    <= (hi_c >= lo_c) ? (hi_c - lo_c) : (lo_c - hi_c);
			neg_s1    <= hi_c < lo_c;
			sector_s1 <= sector_c;
		end
	end

	// Stage 2: form the rounded-division numerators and divisors.
	//   hue offset = (120 * mag + spread) / (2 * spread)
	//   saturation = (510 * spread + max) / (2 * max)
	// Adding half the divisor before a floor division rounds half up.
	rth_div_t div_in_c;
	logic     div_in_ready;

	always_comb begin
		div_in_c.hue_rem = HueNumW'(HueSector) * HueNumW'(mag_s1) + HueNumW'(spread_s1);
		div_in_c.hue_den = {spread_s1, 1'b0};
		div_in_c.hue_quo = '0;
		div_in_c.sat_rem = SatNumW'(SatScale2) * SatNumW'(spread_s1) + SatNumW'(value_s1);
		div_in_c.sat_den = {value_s1, 1'b0};
		div_in_c.sat_quo = '0;
		div_in_c.grey    = spread_s1 == '0;
		div_in_c.black   = value_s1 == '0;
		div_in_c.sector  = sector_s1;
		div_in_c.neg     = neg_s1;
		div_in_c.value   = value_s1;
	end

	assign ready_s2 = !valid_s2 || div_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			data_s2 <= div_in_c;
		end
	end

	// Stages 3 to 10: both divisions, one quotient bit per stage.
	logic     div_out_valid;
	rth_div_t div_out_data;
	logic     ready_s11;

	rth_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_ready  (div_in_ready),
		.in_data   (data_s2),
		.out_valid (div_out_valid),
		.out_ready (ready_s11),
		.out_data  (div_out_data)
	);

	// Stage 11: add the signed offset to the sector base and wrap at 360.
	// A grey pixel keeps the base, so its divider result is ignored; a black
	// pixel has zero saturation for the same reason.
	logic [HueSumW-1:0] base_c;
	logic [HueSumW-1:0] offset_c;
	logic [HueSumW-1:0] sum_c;
	logic [HueW-1:0]    hue_c;
	logic [SatW-1:0]    sat_c;

	always_comb begin
		case (div_out_data.sector)
			SECT_RED:   base_c = HueSumW'(HueFull);
			SECT_GREEN: base_c = HueSumW'(HueGreen);
			SECT_BLUE:  base_c = HueSumW'(HueBlue);
			default:    base_c = '0;
		endcase
		offset_c = div_out_data.grey ? '0 : HueSumW'(div_out_data.hue_quo);
		sum_c    = div_out_data.neg ? (base_c - offset_c) : (base_c + offset_c);
		if (sum_c >= HueSumW'(HueFull)) begin
			sum_c = sum_c - HueSumW'(HueFull);
		end
		hue_c = sum_c[HueW-1:0];
		sat_c = div_out_data.black ? '0 : div_out_data.sat_quo;
	end

	logic              valid_s11;
	logic [HueW-1:0]   hue_s11;
	logic [SatW-1:0]   sat_s11;
	logic [ChanW-1:0]  value_s11;

	assign ready_s11 = !valid_s11 || !hsv_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else if (ready_s11) begin
			valid_s11 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s11 && div_out_valid) begin
			hue_s11   <= hue_c;
			sat_s11   <= sat_c;
			value_s11 <= div_out_data.value;
		end
	end

	assign hsv_valid      = valid_s11;
	assign hue_deg        = hue_s11;
	assign saturation_out = sat_s11;
	assign value_out      = value_s11;

	// Zero saturation only comes from a grey pixel, whose hue is always zero.
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && saturation_out == '0 |-> hue_deg == '0)
		else $error("grey pixel produced a nonzero hue");

	// The wrap must keep the hue below a full turn.
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> hue_deg < HueW'(HueFull))
		else $error("hue out of range");

	// Bubbles close up, so the input only stalls behind a stalled, full output.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> hsv_valid && hsv_stall && valid_s1 && valid_s2)
		else $error("input stalled while the pipeline had room");

	// An accepted beat always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |=> valid_s1)
		else $error("accepted beat lost at stage one");

endmodule

>>> tb/rgb_to_hsv_pixel_checker.sv
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pix_valid,
	input  logic                      pix_stall,
	input  logic [rth_pkg::ChanW-1:0] red_in,
	input  logic [rth_pkg::ChanW-1:0] green_in,
	input  logic [rth_pkg::ChanW-1:0] blue_in,
	input  logic                      hsv_valid,
	input  logic                      hsv_stall,
	input  logic [rth_pkg::HueW-1:0]  hue_deg,
	input  logic [rth_pkg::SatW-1:0]  saturation_out,
	input  logic [rth_pkg::ChanW-1:0] value_out,
	output int                        mismatches,
	output int                        pending
);

	import rth_pkg::*;

	typedef struct packed {
		logic [HueW-1:0]  hue;
		logic [SatW-1:0]  sat;
		logic [ChanW-1:0] value;
	} hsv_t;

	hsv_t expected_hsv[$];

	// Integer HSV of one pixel. The largest channel picks the base angle, ties
	// going to red and then green; hue and saturation round half away from zero.
	function automatic hsv_t hsv_of_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
			logic [ChanW-1:0] b);
		int unsigned peak, trough, spread, lo, hi, mag, quo;
		int          base, angle;
		rth_sector_t sector;
		hsv_t        res;
		peak   = r;
		trough = r;
		if (g > peak) peak = g;
		if (b > peak) peak = b;
		if (g < trough) trough = g;
		if (b < trough) trough = b;
		spread = peak - trough;
		res.value = peak[ChanW-1:0];
		if (peak == 0)
			res.sat = '0;
		else
			res.sat = SatW'((SatScale2 * spread + peak) / (2 * peak));
		if (r >= g && r >= b)
			sector = SECT_RED;
		else if (g >= b)
			sector = SECT_GREEN;
		else
			sector = SECT_BLUE;
		case (sector)
			SECT_RED: begin
				base = HueFull;
				lo   = b;
				hi   = g;
			end
			SECT_GREEN: begin
				base = HueGreen;
				lo   = r;
				hi   = b;
			end
			default: begin
				base = HueBlue;
				lo   = g;
				hi   = r;
			end
		endcase
		angle = base;
		if (spread != 0) begin
			mag = (hi >= lo) ? hi - lo : lo - hi;
			quo = (HueSector * mag + spread) / (2 * spread);
			angle = (hi >= lo) ? base + int'(quo) : base - int'(quo);
		end
		res.hue = HueW'(angle % HueFull);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hsv_t want;
		if (!arst_n) begin
			expected_hsv.delete();
			pending    = 0;
			mismatches = 0;
		end else begin
			if (pix_valid && !pix_stall)
				expected_hsv.push_back(hsv_of_pixel(red_in, green_in, blue_in));
			if (hsv_valid && !hsv_stall) begin
				if (expected_hsv.size() == 0) begin
					$display("%0t: result beat with nothing expected: hue %0d sat %0d value %0d",
						$time, hue_deg, saturation_out, value_out);
					mismatches++;
				end else begin
					want = expected_hsv.pop_front();
					if (hue_deg !== want.hue) begin
						$display("%0t: hue_deg expected %0d actual %0d", $time, want.hue, hue_deg);
						mismatches++;
					end
					if (saturation_out !== want.sat) begin
						$display("%0t: saturation_out expected %0d actual %0d", $time, want.sat,
							saturation_out);
						mismatches++;
					end
					if (value_out !== want.value) begin
						$display("%0t: value_out expected %0d actual %0d", $time, want.value,
							value_out);
						mismatches++;
					end
				end
			end
			pending = expected_hsv.size();
		end
	end

endmodule

>>> tb/rgb_to_hsv_pixel_unit_test.sv
`timescale 1ns / 1ps

// Top of the pixel converter bench. This module only makes pixels, drives the
// receiver's stall and gives the verdict; the checker beside the block records
// every accepted pixel beat, predicts its hue, saturation and value, and
// compares each accepted result beat in order.
module rgb_to_hsv_pixel_unit_test;

	import rth_pkg::*;

	// The quiet tail at the end is longer than the pipeline, so any stray result
	// beat has time to show up.
	localparam int TailCycles = 20;
	// A run of about 1070 pixels, even under the heaviest idling, ends far below
	// the limit.
	localparam int CycleLimit = 200000;
	localparam int PixelsPerPhase = 350;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                pix_valid = 1'b0;
	logic                pix_stall;
	logic [ChanW-1:0]    red_in = '0;
	logic [ChanW-1:0]    green_in = '0;
	logic [ChanW-1:0]    blue_in = '0;
	logic                hsv_valid;
	logic                hsv_stall = 1'b0;
	logic [HueW-1:0]     hue_deg;
	logic [SatW-1:0]     saturation_out;
	logic [ChanW-1:0]    value_out;

	int mismatches;
	int pending;
	int cycle_count = 0;

	// Chance in percent that the sender idles or the receiver stalls in a cycle.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	rgb_to_hsv_pixel_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.pix_valid      (pix_valid),
		.pix_stall      (pix_stall),
		.red_in         (red_in),
		.green_in       (green_in),
		.blue_in        (blue_in),
		.hsv_valid      (hsv_valid),
		.hsv_stall      (hsv_stall),
		.hue_deg        (hue_deg),
		.saturation_out (saturation_out),
		.value_out      (value_out)
	);

	rgb_to_hsv_pixel_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.pix_valid      (pix_valid),
		.pix_stall      (pix_stall),
		.red_in         (red_in),
		.green_in       (green_in),
		.blue_in        (blue_in),
		.hsv_valid      (hsv_valid),
		.hsv_stall      (hsv_stall),
		.hue_deg        (hue_deg),
		.saturation_out (saturation_out),
		.value_out      (value_out),
		.mismatches     (mismatches),
		.pending        (pending)
	);

	always #6 clk = ~clk;

	// The receiver decides afresh every cycle whether to stall, so stalls land
	// on every pipeline phase, including the cycles where the block is full.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_stall <= 1'b0;
		end else begin
			hsv_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Offer one pixel beat, after a random number of idle cycles, and hold it
	// until the block takes it. The task returns in the time step of the edge
	// that accepted the beat, so the next call can keep valid high without a
	// second assignment in that step.
	task automatic send_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
			input logic [ChanW-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		red_in    <= r;
		green_in  <= g;
		blue_in   <= b;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
	endtask

	// Stop sending and wait until every predicted result has come out. The
	// count is read at the falling edge, clear of the checker's updates.
	task automatic wait_drained();
		pix_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// Random pixel with a bias toward the awkward shapes: greys, ties for the
	// largest channel, channels pinned at the rails, a single lit channel and
	// nearly grey pixels where the spread is tiny and rounding matters most.
	task automatic pick_pixel(output logic [ChanW-1:0] r, output logic [ChanW-1:0] g,
			output logic [ChanW-1:0] b);
		logic [ChanW-1:0] top, rest;
		int               shape;
		shape = $urandom_range(9);
		r = ChanW'($urandom_range(255));
		g = ChanW'($urandom_range(255));
		b = ChanW'($urandom_range(255));
		case (shape)
			5: begin
				g = r;
				b = r;
			end
			6: begin
				top  = ChanW'($urandom_range(255));
				rest = ChanW'($urandom_range(top));
				case ($urandom_range(2))
					0: begin r = top; g = top; b = rest; end
					1: begin r = rest; g = top; b = top; end
					default: begin r = top; g = rest; b = top; end
				endcase
			end
			7: begin
				r = $urandom_range(1) ? 8'd255 - 8'($urandom_range(1)) : 8'($urandom_range(1));
				g = $urandom_range(1) ? 8'd255 - 8'($urandom_range(1)) : 8'($urandom_range(1));
				b = $urandom_range(1) ? 8'd255 - 8'($urandom_range(1)) : 8'($urandom_range(1));
			end
			8: begin
				case ($urandom_range(2))
					0: begin g = '0; b = '0; end
					1: begin r = '0; b = '0; end
					default: begin r = '0; g = '0; end
				endcase
			end
			9: begin
				top = ChanW'($urandom_range(2, 253));
				r = top + 8'($urandom_range(2)) - 8'd1;
				g = top + 8'($urandom_range(2)) - 8'd1;
				b = top + 8'($urandom_range(2)) - 8'd1;
			end
			default: ;
		endcase
	endtask

	initial begin
		logic [ChanW-1:0] r, g, b;

		// Reset is held from the start, then released once for good.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First phase: sender idles now and then, receiver stalls often.
		send_idle_pct  = 23;
		recv_stall_pct = 46;

		// Directed corners. Black and white, the pure primaries and
		// secondaries, ties for the largest channel in every pairing, a grey,
		// the smallest possible spreads, and hue and saturation quotients that
		// land exactly on a half so the rounding direction shows, both above
		// and below the red base so the wrap past 360 is exercised.
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd120, 8'd1, 8'd0);
		send_pixel(8'd120, 8'd0, 8'd1);
		send_pixel(8'd2, 8'd1, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd0);
		send_pixel(8'd254, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd254, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd254);
		send_pixel(8'd10, 8'd200, 8'd50);
		send_pixel(8'd170, 8'd85, 8'd0);
		send_pixel(8'd85, 8'd170, 8'd255);

		// Random phases. Midway through each one the sender holds off until
		// the pipeline has emptied, so the block also sees a cold restart.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 23; recv_stall_pct = 46; end
				1: begin send_idle_pct = 46; recv_stall_pct = 23; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			for (int n = 0; n < PixelsPerPhase; n++) begin
				if (n == PixelsPerPhase / 2)
					wait_drained();
				pick_pixel(r, g, b);
				send_pixel(r, g, b);
			end
		end

		wait_drained();
		repeat (TailCycles) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
